/* design/mac_command_responder_core_assert.svh */
// assertion macros shared by the command responder modules
// expects clk and rst in scope where used
`ifndef MAC_COMMAND_RESPONDER_CORE_ASSERT_SVH
`define MAC_COMMAND_RESPONDER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcr assertion failed");

// next-cycle implication, disabled in reset
`define MCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcr assertion failed");

`endif

/* design/mcr_pkg.sv */
// shared constants, command decode functions and control structs
// for the mac command responder; no dependencies
package mcr_pkg;

  localparam int QUEUE_BYTES = 15;
  localparam int QIDX_W      = $clog2(QUEUE_BYTES);
  localparam int COUNT_W     = 4;
  localparam int REM_W       = 3;

  localparam logic [7:0] CMD_LINK_ADR     = 8'h03;
  localparam logic [7:0] CMD_RX_PARAM     = 8'h05;
  localparam logic [7:0] CMD_NEW_CHANNEL  = 8'h07;
  localparam logic [7:0] CMD_RX_TIMING    = 8'h08;
  localparam logic [7:0] CMD_PING_CHANNEL = 8'h11;

  localparam logic [7:0] ACK_THREE = 8'h07;
  localparam logic [7:0] ACK_TWO   = 8'h03;
  localparam logic [7:0] BYTE_NONE = 8'h00;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_TRUNC  = 2'd1;
  localparam logic [1:0] STATUS_UNSUPP = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;
  localparam logic MODE_DRAIN  = 1'b1;

  // total command length including the id, zero for an unknown id
  function automatic logic [REM_W-1:0] cmd_length(input logic [7:0] id);
    logic [REM_W-1:0] len;
    unique case (id) inside
      CMD_LINK_ADR, CMD_RX_PARAM, CMD_PING_CHANNEL: len = REM_W'(5);
      CMD_NEW_CHANNEL:                              len = REM_W'(6);
      CMD_RX_TIMING:                                len = REM_W'(2);
      default:                                      len = '0;
    endcase
    return len;
  endfunction

  // second answer byte, where the answer has one
  function automatic logic [7:0] answer_second(input logic [7:0] id);
    logic [7:0] ans;
    unique case (id) inside
      CMD_LINK_ADR, CMD_RX_PARAM:        ans = ACK_THREE;
      CMD_NEW_CHANNEL, CMD_PING_CHANNEL: ans = ACK_TWO;
      default:                           ans = BYTE_NONE;
    endcase
    return ans;
  endfunction

  function automatic logic answer_is_two(input logic [7:0] id);
    return id != CMD_RX_TIMING;
  endfunction

  typedef struct packed {
    logic parse_en;
    logic drain_start;
    logic emit_status;
    logic emit_answer;
  } mcr_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic drain_final;
  } mcr_sts_t;

endpackage

/* design/mcr_ctrl.sv */
// controller state machine for the mac command responder
// depends on mcr_pkg and mac_command_responder_core_assert.svh
`include "mac_command_responder_core_assert.svh"

module mcr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic              last,
  input  mcr_pkg::mcr_sts_t sts,
  output mcr_pkg::mcr_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_STATUS = 3'b010,
    S_DRAIN  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == mcr_pkg::MODE_DRAIN) begin
            cmd.drain_start = 1'b1;
            state_next      = S_DRAIN;
          end else begin
            cmd.parse_en = 1'b1;
            if (last) begin
              state_next = S_STATUS;
            end
          end
        end
      end
      S_STATUS: begin
        if (!sts.out_busy) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (!sts.out_busy) begin
          cmd.emit_answer = 1'b1;
          if (sts.drain_final) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `MCR_ASSERT_NEXT(a_drain_entered, accept && mode == mcr_pkg::MODE_DRAIN, state == S_DRAIN)
  `MCR_ASSERT_NEXT(a_last_reports, accept && mode != mcr_pkg::MODE_DRAIN && last,
                   state == S_STATUS)
  `MCR_ASSERT_NOW(a_one_emit, cmd.emit_status || cmd.emit_answer,
                  !(cmd.parse_en || cmd.drain_start))

endmodule

/* design/mcr_dpath.sv */
// datapath for the mac command responder: parser registers, answer queue,
// drain counter and result register; depends on mcr_pkg and the assert header
`include "mac_command_responder_core_assert.svh"

module mcr_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  mcr_pkg::mcr_cmd_t             cmd,
  output mcr_pkg::mcr_sts_t             sts,
  input  logic [7:0]                    cmd_byte,
  input  logic                          last,
  input  logic                          keep_answers,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [7:0]                    answer_byte,
  output logic                          answer_last,
  output logic [1:0]                    parse_status,
  output logic [mcr_pkg::COUNT_W-1:0]   pending_count
);

  logic [7:0]                   answer_queue [mcr_pkg::QUEUE_BYTES];
  logic [mcr_pkg::COUNT_W-1:0]  answer_count;
  logic [mcr_pkg::COUNT_W-1:0]  answer_count_next;
  logic [7:0]                   current_command;
  logic [7:0]                   current_command_next;
  logic [mcr_pkg::REM_W-1:0]    bytes_remaining;
  logic [mcr_pkg::REM_W-1:0]    bytes_remaining_next;
  logic                         skip_rest;
  logic                         skip_rest_next;
  logic [1:0]                   status_hold;

  logic [mcr_pkg::COUNT_W-1:0]  drain_n;
  logic [mcr_pkg::QIDX_W-1:0]   drain_idx;
  logic                         drain_keep;

  logic                         push;
  logic                         push_two;
  logic                         push_ok;
  logic [mcr_pkg::COUNT_W:0]    fill_sum;
  logic [mcr_pkg::COUNT_W-1:0]  wr_addr1;
  logic [mcr_pkg::REM_W-1:0]    id_len;
  logic [7:0]                   second_byte;

  assign id_len      = mcr_pkg::cmd_length(cmd_byte);
  assign push_two    = mcr_pkg::answer_is_two(current_command);
  assign second_byte = mcr_pkg::answer_second(current_command);
  assign fill_sum    = {1'b0, answer_count} + (push_two ? (mcr_pkg::COUNT_W+1)'(2)
                                                        : (mcr_pkg::COUNT_W+1)'(1));
  assign wr_addr1    = answer_count + mcr_pkg::COUNT_W'(1);

  // parser next state for one buffer byte
  always_comb begin
    skip_rest_next       = skip_rest;
    bytes_remaining_next = bytes_remaining;
    current_command_next = current_command;
    push                 = 1'b0;
    if (!skip_rest) begin
      if (bytes_remaining == '0) begin
        if (id_len == '0) begin
          skip_rest_next = 1'b1;
        end else begin
          current_command_next = cmd_byte;
          bytes_remaining_next = id_len - mcr_pkg::REM_W'(1);
        end
      end else begin
        bytes_remaining_next = bytes_remaining - mcr_pkg::REM_W'(1);
        push                 = (bytes_remaining_next == '0);
      end
    end
  end

  // answer dropped when it would overflow the queue
  assign push_ok = cmd.parse_en && push &&
                   (fill_sum <= (mcr_pkg::COUNT_W+1)'(mcr_pkg::QUEUE_BYTES));

  assign sts.out_busy    = out_valid && out_stall;
  assign sts.drain_final = (drain_n == '0) ||
                           (mcr_pkg::COUNT_W'(drain_idx) == drain_n - mcr_pkg::COUNT_W'(1));

  always_comb begin
    answer_count_next = answer_count;
    if (push_ok) begin
      answer_count_next = fill_sum[mcr_pkg::COUNT_W-1:0];
    end else if (cmd.emit_answer && sts.drain_final && !drain_keep) begin
      answer_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < mcr_pkg::QUEUE_BYTES; i++) begin
      if (push_ok && answer_count == mcr_pkg::COUNT_W'(i)) begin
        answer_queue[i] <= current_command;
      end
      if (push_ok && push_two && wr_addr1 == mcr_pkg::COUNT_W'(i)) begin
        answer_queue[i] <= second_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_count    <= '0;
      current_command <= '0;
      bytes_remaining <= '0;
      skip_rest       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      answer_count <= answer_count_next;
      if (cmd.parse_en) begin
        if (last) begin
          // buffer end: parser goes back to expecting an id
          current_command <= '0;
          bytes_remaining <= '0;
          skip_rest       <= 1'b0;
        end else begin
          current_command <= current_command_next;
          bytes_remaining <= bytes_remaining_next;
          skip_rest       <= skip_rest_next;
        end
      end
      if (cmd.emit_status || cmd.emit_answer) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.parse_en && last) begin
      if (skip_rest_next) begin
        status_hold <= mcr_pkg::STATUS_UNSUPP;
      end else if (bytes_remaining_next != '0) begin
        status_hold <= mcr_pkg::STATUS_TRUNC;
      end else begin
        status_hold <= mcr_pkg::STATUS_OK;
      end
    end
    if (cmd.drain_start) begin
      drain_n    <= answer_count;
      drain_idx  <= '0;
      drain_keep <= keep_answers;
    end else if (cmd.emit_answer) begin
      drain_idx <= drain_idx + mcr_pkg::QIDX_W'(1);
    end
    if (cmd.emit_status) begin
      kind          <= mcr_pkg::KIND_STATUS;
      answer_byte   <= mcr_pkg::BYTE_NONE;
      answer_last   <= 1'b0;
      parse_status  <= status_hold;
      pending_count <= answer_count;
    end else if (cmd.emit_answer) begin
      kind          <= mcr_pkg::KIND_ANSWER;
      answer_byte   <= (drain_n == '0) ? mcr_pkg::BYTE_NONE : answer_queue[drain_idx];
      answer_last   <= sts.drain_final;
      parse_status  <= mcr_pkg::STATUS_OK;
      pending_count <= drain_n;
    end
  end

  `MCR_ASSERT_NOW(a_count_bound, 1'b1, answer_count <= mcr_pkg::COUNT_W'(mcr_pkg::QUEUE_BYTES))
  `MCR_ASSERT_NOW(a_no_overwrite, cmd.emit_status || cmd.emit_answer, !sts.out_busy)
  `MCR_ASSERT_NOW(a_idx_in_run, cmd.emit_answer && drain_n != '0,
                  mcr_pkg::COUNT_W'(drain_idx) < drain_n)

endmodule

/* design/mac_command_responder_core.sv */
// top level of the mac command responder: controller plus datapath
// depends on mcr_pkg, mcr_ctrl and mcr_dpath

// Takes one item at a time. A buffer byte that is not the last gives no result;
// a last byte moves the controller into its status state, which gives one status
// result once the output register is free. A drain, once accepted, gives one
// answer byte per cycle while the output side does not stall, or a single empty
// marker for an empty queue, since every result passes through the single output
// register. The answer queue needs no clearing after reset.
module mac_command_responder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [7:0]                  cmd_byte,
  input  logic                        last,
  input  logic                        keep_answers,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kind,
  output logic [7:0]                  answer_byte,
  output logic                        answer_last,
  output logic [1:0]                  parse_status,
  output logic [mcr_pkg::COUNT_W-1:0] pending_count
);

  mcr_pkg::mcr_cmd_t cmd;
  mcr_pkg::mcr_sts_t sts;

  mcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .last     (last),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcr_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cmd_byte      (cmd_byte),
    .last          (last),
    .keep_answers  (keep_answers),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .answer_byte   (answer_byte),
    .answer_last   (answer_last),
    .parse_status  (parse_status),
    .pending_count (pending_count)
  );

endmodule

/* tb/sv/mac_command_responder_core_test.sv */
// self-checking testbench for mac_command_responder_core: directed table then random buffers
// depends on mcr_pkg and the responder rtl; predicts or looks up every result, checks each field
module mac_command_responder_core_test;

  localparam logic MODE_BYTE    = 1'b0;
  localparam int   RANDOM_ITEMS = 360;

  // known commands: id, total length, second answer byte (none for a one-byte answer)
  localparam logic [7:0] KNOWN_IDS [5] = '{mcr_pkg::CMD_LINK_ADR, mcr_pkg::CMD_NEW_CHANNEL,
                                           mcr_pkg::CMD_RX_PARAM, mcr_pkg::CMD_RX_TIMING,
                                           mcr_pkg::CMD_PING_CHANNEL};
  localparam int         KNOWN_SPANS [5] = '{5, 6, 5, 2, 5};
  localparam logic [7:0] KNOWN_REPLY [5] = '{mcr_pkg::ACK_THREE, mcr_pkg::ACK_TWO,
                                             mcr_pkg::ACK_THREE, mcr_pkg::BYTE_NONE,
                                             mcr_pkg::ACK_TWO};

  typedef struct packed {
    logic       mode;
    logic [7:0] cbyte;
    logic       fin;
    logic       keep;
  } req_t;

  typedef struct packed {
    logic                        kind;
    logic [7:0]                  abyte;
    logic                        alast;
    logic [1:0]                  status;
    logic [mcr_pkg::COUNT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t want;
  } row_t;

  localparam rsp_t EMPTY_MARKER = '{mcr_pkg::KIND_ANSWER, mcr_pkg::BYTE_NONE, 1'b1,
                                    mcr_pkg::STATUS_OK, '0};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        mode = 1'b0;
  logic [7:0]                  cmd_byte = '0;
  logic                        last = 1'b0;
  logic                        keep_answers = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        kind;
  logic [7:0]                  answer_byte;
  logic                        answer_last;
  logic [1:0]                  parse_status;
  logic [mcr_pkg::COUNT_W-1:0] pending_count;

  mac_command_responder_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .cmd_byte     (cmd_byte),
    .last         (last),
    .keep_answers (keep_answers),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .answer_byte  (answer_byte),
    .answer_last  (answer_last),
    .parse_status (parse_status),
    .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rsp_t due_results[$];
  int   mismatches = 0;
  int   sent = 0;
  bit   no_idle = 1'b0;

  // predicted responder state
  logic [7:0] held_bytes [mcr_pkg::QUEUE_BYTES];
  int         held = 0;
  int         remaining = 0;
  int         cur_slot = 0;
  bit         skipping = 1'b0;

  function automatic void respond_to_item(input req_t r, ref rsp_t res[$]);
    int         found;
    int         alen;
    logic [1:0] st;
    if (r.mode == mcr_pkg::MODE_DRAIN) begin
      if (held == 0) begin
        res.push_back(EMPTY_MARKER);
        return;
      end
      for (int k = 0; k < held; k++)
        res.push_back('{mcr_pkg::KIND_ANSWER, held_bytes[k], k == held - 1,
                        mcr_pkg::STATUS_OK, mcr_pkg::COUNT_W'(held)});
      if (!r.keep) held = 0;
      return;
    end
    if (!skipping) begin
      if (remaining == 0) begin
        found = -1;
        for (int s = 0; s < 5; s++)
          if (KNOWN_IDS[s] == r.cbyte) found = s;
        if (found < 0) begin
          skipping = 1'b1;
        end else begin
          cur_slot  = found;
          remaining = KNOWN_SPANS[found] - 1;
        end
      end else begin
        remaining--;
        if (remaining == 0) begin
          // an answer that would overflow the queue is dropped whole
          alen = (KNOWN_REPLY[cur_slot] == mcr_pkg::BYTE_NONE) ? 1 : 2;
          if (held + alen <= mcr_pkg::QUEUE_BYTES) begin
            held_bytes[held] = KNOWN_IDS[cur_slot];
            if (alen == 2) held_bytes[held + 1] = KNOWN_REPLY[cur_slot];
            held += alen;
          end
        end
      end
    end
    if (!r.fin) return;
    st = skipping ? mcr_pkg::STATUS_UNSUPP
                  : (remaining != 0 ? mcr_pkg::STATUS_TRUNC : mcr_pkg::STATUS_OK);
    res.push_back('{mcr_pkg::KIND_STATUS, mcr_pkg::BYTE_NONE, 1'b0, st,
                    mcr_pkg::COUNT_W'(held)});
    remaining = 0;
    skipping  = 1'b0;
    cur_slot  = 0;
  endfunction

  task automatic send(input req_t r, input logic typed, input rsp_t want);
    rsp_t scratch[$];
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= r.mode;
    cmd_byte     <= r.cbyte;
    last         <= r.fin;
    keep_answers <= r.keep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    respond_to_item(r, scratch);
    if (typed) due_results.push_back(want);
    else foreach (scratch[i]) due_results.push_back(scratch[i]);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) out_stall <= !no_idle && ($urandom_range(0, 99) < 27);

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected item expected none actual kind %0h byte %0h status %0h",
                 $time, kind, answer_byte, parse_status);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 8'(want.kind), 8'(kind));
        check_field("answer_byte", want.abyte, answer_byte);
        check_field("answer_last", 8'(want.alast), 8'(answer_last));
        check_field("parse_status", 8'(want.status), 8'(parse_status));
        check_field("pending_count", 8'(want.count), 8'(pending_count));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    row_t       script [25];
    logic [7:0] chunk[$];
    int         pick;
    int         ncmd;
    int         slot;
    int         cut;
    bit         paused;
    paused = 1'b0;
    script = '{
      '{'{mcr_pkg::MODE_DRAIN, 8'hFF, 1'b1, 1'b0}, 1'b1, EMPTY_MARKER},
      '{'{MODE_BYTE, mcr_pkg::CMD_RX_TIMING, 1'b0, 1'b1}, 1'b0, '0},
      '{'{MODE_BYTE, 8'hFF, 1'b1, 1'b0}, 1'b1,
        '{mcr_pkg::KIND_STATUS, mcr_pkg::BYTE_NONE, 1'b0, mcr_pkg::STATUS_OK, 4'd1}},
      '{'{MODE_BYTE, mcr_pkg::CMD_LINK_ADR, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'hFF, 1'b0, 1'b1}, 1'b0, '0},
      '{'{MODE_BYTE, 8'h80, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'h01, 1'b1, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, mcr_pkg::CMD_NEW_CHANNEL, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'hAA, 1'b1, 1'b0}, 1'b1,
        '{mcr_pkg::KIND_STATUS, mcr_pkg::BYTE_NONE, 1'b0, mcr_pkg::STATUS_TRUNC, 4'd3}},
      '{'{MODE_BYTE, 8'h42, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, mcr_pkg::CMD_RX_PARAM, 1'b1, 1'b1}, 1'b1,
        '{mcr_pkg::KIND_STATUS, mcr_pkg::BYTE_NONE, 1'b0, mcr_pkg::STATUS_UNSUPP, 4'd3}},
      '{'{mcr_pkg::MODE_DRAIN, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
      '{'{MODE_BYTE, mcr_pkg::CMD_PING_CHANNEL, 1'b0, 1'b0}, 1'b0, '0},
      // drain in the middle of a command leaves the parser where it was
      '{'{mcr_pkg::MODE_DRAIN, 8'hFF, 1'b1, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'h01, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'h02, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'h03, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'h04, 1'b1, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, mcr_pkg::CMD_RX_PARAM, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'h7F, 1'b0, 1'b1}, 1'b0, '0},
      '{'{MODE_BYTE, 8'hFE, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'h55, 1'b0, 1'b0}, 1'b0, '0},
      '{'{MODE_BYTE, 8'hAA, 1'b1, 1'b0}, 1'b0, '0},
      '{'{mcr_pkg::MODE_DRAIN, 8'h00, 1'b0, 1'b0}, 1'b0, '0}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send(script[i].req, script[i].typed, script[i].want);

    while (sent < $size(script) + RANDOM_ITEMS) begin
      no_idle = (sent >= 140 && sent < 220);
      if (!paused && sent >= 260) begin
        // hold the sender off until the output side has caught up
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        send('{mcr_pkg::MODE_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               ($urandom_range(0, 99) < 35)}, 1'b0, '0);
      end else begin
        chunk.delete();
        ncmd = $urandom_range(1, 4);
        for (int k = 0; k < ncmd; k++) begin
          slot = $urandom_range(0, 4);
          chunk.push_back(KNOWN_IDS[slot]);
          repeat (KNOWN_SPANS[slot] - 1) chunk.push_back(8'($urandom_range(0, 255)));
        end
        // broken buffers: cut short, a stray byte slipped in, or pure noise
        if (pick >= 84) begin
          case ($urandom_range(0, 2))
            0: begin
              cut = $urandom_range(1, chunk.size());
              while (chunk.size() > cut) void'(chunk.pop_back());
            end
            1: chunk.insert($urandom_range(0, chunk.size() - 1), 8'($urandom_range(0, 255)));
            default: begin
              chunk.delete();
              repeat ($urandom_range(1, 6)) chunk.push_back(8'($urandom_range(0, 255)));
            end
          endcase
        end
        foreach (chunk[i]) begin
          if (i > 0 && $urandom_range(0, 99) < 6)
            send('{mcr_pkg::MODE_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1))}, 1'b0, '0);
          send('{MODE_BYTE, chunk[i], i == chunk.size() - 1, 1'($urandom_range(0, 1))},
               1'b0, '0);
        end
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
